/* hdl/srrb_pkg.sv */
// srrb_pkg: shared constants, types and helpers for the serial receive ring
// depends on nothing; used by all files in hdl
package srrb_pkg;

	// ring geometry
	localparam int RING_DEPTH = 64;
	localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CNT_W      = $clog2(RING_DEPTH + 1);
	localparam int THR_W      = 7;
	localparam int CMP_W      = (CNT_W > THR_W) ? CNT_W : THR_W;
	localparam int ENTRY_W    = 16;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = THR_W;
	localparam logic [CFG_IDX_W-1:0] CFG_SI_SO     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEL_EN    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEL_NULL  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FLOW_EN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd4;
	localparam logic [THR_W-1:0]     THRESHOLD_RST = 7'd48;

	// item kinds
	localparam logic [1:0] KIND_RX      = 2'd0;
	localparam logic [1:0] KIND_TAKE    = 2'd1;
	localparam logic [1:0] KIND_RELEASE = 2'd2;

	// character codes and masks
	localparam logic [7:0] CODE_SO     = 8'h0e;
	localparam logic [7:0] CODE_SI     = 8'h0f;
	localparam logic [7:0] CODE_XOFF   = 8'h13;
	localparam logic [7:0] CODE_SPACE  = 8'h20;
	localparam logic [7:0] MASK_BIT7   = 8'h80;
	localparam logic [7:0] MASK_LOW7   = 8'h7f;
	localparam logic [6:0] CODE_DEL7   = 7'h7f;
	localparam logic [7:0] MASK_LSR    = 8'hfc;

	// controller state, one-hot
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic capture;
		logic commit;
	} cmd_t;

	// ring index increment with wrap
	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
		return (i == IDX_W'(RING_DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

endpackage

/* hdl/srrb_if.sv */
// srrb_item_if and srrb_result_if: valid/ready channels of the receive ring
// depends on srrb_pkg
interface srrb_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] rx_byte;
	logic [7:0] line_status;
	logic [7:0] modem_bits;

	modport source (output valid, kind, rx_byte, line_status, modem_bits, input ready);
	modport sink   (input valid, kind, rx_byte, line_status, modem_bits, output ready);
endinterface

interface srrb_result_if;
	logic                     valid;
	logic                     ready;
	logic                     stored;
	logic                     send_valid;
	logic [7:0]               send_byte;
	logic                     take_valid;
	logic [7:0]               take_data;
	logic [7:0]               take_status;
	logic                     overflow;
	logic [srrb_pkg::CNT_W-1:0] level;

	modport source (output valid, stored, send_valid, send_byte, take_valid, take_data,
		take_status, overflow, level, input ready);
	modport sink   (input valid, stored, send_valid, send_byte, take_valid, take_data,
		take_status, overflow, level, output ready);
endinterface

/* hdl/srrb_ctrl.sv */
// srrb_ctrl: two-state sequencer and output beat valid for the receive ring
// depends on srrb_pkg
module srrb_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output srrb_pkg::cmd_t  cmd
);

	srrb_pkg::state_t state_q, state_d;
	logic             out_valid_q;
	logic             out_free;

	// the output register can take a result when empty or being drained
	assign out_free    = !out_valid_q || out_ready;
	assign in_ready    = (state_q == srrb_pkg::ST_IDLE);
	assign cmd.capture = in_ready && in_valid;
	assign cmd.commit  = (state_q == srrb_pkg::ST_EXEC) && out_free;
	assign out_valid   = out_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			srrb_pkg::ST_IDLE: begin
				if (in_valid) state_d = srrb_pkg::ST_EXEC;
			end
			srrb_pkg::ST_EXEC: begin
				if (out_free) state_d = srrb_pkg::ST_IDLE;
			end
			default: state_d = srrb_pkg::ST_IDLE;
		endcase
	end

	// state and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= srrb_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

/* hdl/srrb_dpath.sv */
// srrb_dpath: ring memory, indices, flags, byte translation and result register
// depends on srrb_pkg
module srrb_dpath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  srrb_pkg::cmd_t                  cmd,
	input  logic                            cfg_we,
	input  logic [srrb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [srrb_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [1:0]                      in_kind,
	input  logic [7:0]                      in_rx_byte,
	input  logic [7:0]                      in_line_status,
	input  logic [7:0]                      in_modem_bits,
	output logic                            res_stored,
	output logic                            res_send_valid,
	output logic [7:0]                      res_send_byte,
	output logic                            res_take_valid,
	output logic [7:0]                      res_take_data,
	output logic [7:0]                      res_take_status,
	output logic                            res_overflow,
	output logic [srrb_pkg::CNT_W-1:0]      res_level
);

	// configuration
	logic                       si_so_q, del_en_q, del_null_q, flow_en_q;
	logic [srrb_pkg::THR_W-1:0] thr_q;

	// ring state
	logic [srrb_pkg::ENTRY_W-1:0] ring_q [srrb_pkg::RING_DEPTH];
	logic [srrb_pkg::IDX_W-1:0]   wr_idx_q, rd_idx_q;
	logic [srrb_pkg::CNT_W-1:0]   count_q;
	logic                         full_q, xoff_q, ovf_q, shift_q;

	// captured item and memory read data
	logic [1:0]                   kind_q;
	logic [7:0]                   byte_q, status_q;
	logic [srrb_pkg::ENTRY_W-1:0] rd_data_q;

	// result register
	logic                       stored_q, send_valid_q, take_valid_q, overflow_q;
	logic [7:0]                 send_byte_q, take_data_q, take_status_q;
	logic [srrb_pkg::CNT_W-1:0] level_q;

	// next-state values
	logic [srrb_pkg::IDX_W-1:0] wr_idx_d, rd_idx_d, wr_inc;
	logic [srrb_pkg::CNT_W-1:0] count_d, count_inc;
	logic                       full_d, xoff_d, ovf_d, shift_d;
	logic                       stored_d, send_d, take_d, swallow;
	logic [7:0]                 data_sh, data_f;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			si_so_q    <= 1'b0;
			del_en_q   <= 1'b0;
			del_null_q <= 1'b0;
			flow_en_q  <= 1'b0;
			thr_q      <= srrb_pkg::THRESHOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				srrb_pkg::CFG_SI_SO:     si_so_q    <= cfg_data[0];
				srrb_pkg::CFG_DEL_EN:    del_en_q   <= cfg_data[0];
				srrb_pkg::CFG_DEL_NULL:  del_null_q <= cfg_data[0];
				srrb_pkg::CFG_FLOW_EN:   flow_en_q  <= cfg_data[0];
				srrb_pkg::CFG_THRESHOLD: thr_q      <= cfg_data[srrb_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	// capture item, merge status, read the oldest entry
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q    <= in_kind;
			byte_q    <= in_rx_byte;
			status_q  <= (in_line_status & srrb_pkg::MASK_LSR) | {6'd0, in_modem_bits[1:0]};
			rd_data_q <= ring_q[rd_idx_q];
		end
	end

	// shift translation then del filtering
	always_comb begin
		data_sh = byte_q;
		swallow = 1'b0;
		shift_d = shift_q;
		if (si_so_q) begin
			if (byte_q >= srrb_pkg::CODE_SPACE) begin
				data_sh = shift_q ? (byte_q | srrb_pkg::MASK_BIT7) :
					(byte_q & srrb_pkg::MASK_LOW7);
			end else if (byte_q == srrb_pkg::CODE_SO) begin
				shift_d = 1'b1;
				swallow = 1'b1;
			end else if (byte_q == srrb_pkg::CODE_SI) begin
				shift_d = 1'b0;
				swallow = 1'b1;
			end
		end
		data_f = (del_en_q && del_null_q && data_sh[6:0] == srrb_pkg::CODE_DEL7) ?
			8'd0 : data_sh;
	end

	assign wr_inc    = srrb_pkg::next_idx(wr_idx_q);
	assign count_inc = count_q + 1'b1;

	// per-kind state update
	always_comb begin
		wr_idx_d = wr_idx_q;
		rd_idx_d = rd_idx_q;
		count_d  = count_q;
		full_d   = full_q;
		xoff_d   = xoff_q;
		ovf_d    = ovf_q;
		stored_d = 1'b0;
		send_d   = 1'b0;
		take_d   = 1'b0;
		unique case (kind_q)
			srrb_pkg::KIND_RX: begin
				if (full_q) begin
					ovf_d = 1'b1;
				end else if (swallow) begin
					stored_d = 1'b0;
				end else begin
					stored_d = 1'b1;
					wr_idx_d = wr_inc;
					count_d  = count_inc;
					if (wr_inc == rd_idx_q) full_d = 1'b1;
					if (flow_en_q && !xoff_q &&
						srrb_pkg::CMP_W'(count_inc) >= srrb_pkg::CMP_W'(thr_q)) begin
						send_d = 1'b1;
						xoff_d = 1'b1;
					end
				end
			end
			srrb_pkg::KIND_TAKE: begin
				if (count_q != '0) begin
					take_d   = 1'b1;
					rd_idx_d = srrb_pkg::next_idx(rd_idx_q);
					count_d  = count_q - 1'b1;
					full_d   = 1'b0;
				end
			end
			srrb_pkg::KIND_RELEASE: begin
				xoff_d = 1'b0;
				ovf_d  = 1'b0;
			end
			default: ;
		endcase
	end

	// control state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			count_q  <= '0;
			full_q   <= 1'b0;
			xoff_q   <= 1'b0;
			ovf_q    <= 1'b0;
			shift_q  <= 1'b0;
		end else if (cmd.commit) begin
			wr_idx_q <= wr_idx_d;
			rd_idx_q <= rd_idx_d;
			count_q  <= count_d;
			full_q   <= full_d;
			xoff_q   <= xoff_d;
			ovf_q    <= ovf_d;
			if (kind_q == srrb_pkg::KIND_RX && !full_q) shift_q <= shift_d;
		end
	end

	// ring write
	always_ff @(posedge clk) begin
		if (cmd.commit && stored_d) ring_q[wr_idx_q] <= {data_f, status_q};
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			stored_q      <= stored_d;
			send_valid_q  <= send_d;
			send_byte_q   <= send_d ? srrb_pkg::CODE_XOFF : 8'd0;
			take_valid_q  <= take_d;
			take_data_q   <= take_d ? rd_data_q[15:8] : 8'd0;
			take_status_q <= take_d ? rd_data_q[7:0] : 8'd0;
			overflow_q    <= ovf_d;
			level_q       <= count_d;
		end
	end

	assign res_stored      = stored_q;
	assign res_send_valid  = send_valid_q;
	assign res_send_byte   = send_byte_q;
	assign res_take_valid  = take_valid_q;
	assign res_take_data   = take_data_q;
	assign res_take_status = take_status_q;
	assign res_overflow    = overflow_q;
	assign res_level       = level_q;

endmodule

/* hdl/serial_rx_ring_buffer_xoff.sv */
// serial receive ring buffer with shift translation, del filtering and xoff
// each item is captured with a registered ring read, then committed to the result
// register once that register is free; a new item is taken only after the last commits
// the next item is accepted while a finished result still waits to be taken
// reset clears indices, count, flags, shift state and configuration; ring
// contents are not cleared and no entry is readable before it is written
module serial_rx_ring_buffer_xoff (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [srrb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [srrb_pkg::CFG_DATA_W-1:0] cfg_data,
	srrb_item_if.sink                       item,
	srrb_result_if.source                   result
);

	srrb_pkg::cmd_t cmd;

	// sequencer
	srrb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd)
	);

	// ring and flags
	srrb_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_kind         (item.kind),
		.in_rx_byte      (item.rx_byte),
		.in_line_status  (item.line_status),
		.in_modem_bits   (item.modem_bits),
		.res_stored      (result.stored),
		.res_send_valid  (result.send_valid),
		.res_send_byte   (result.send_byte),
		.res_take_valid  (result.take_valid),
		.res_take_data   (result.take_data),
		.res_take_status (result.take_status),
		.res_overflow    (result.overflow),
		.res_level       (result.level)
	);

endmodule

/* hdl/srrb_chk.sv */
// srrb_chk: port-level checks on the receive ring, bound to the top level
// depends on srrb_pkg and serial_rx_ring_buffer_xoff
module srrb_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic                       send_valid,
	input logic [7:0]                 send_byte,
	input logic                       take_valid,
	input logic [7:0]                 take_data,
	input logic [7:0]                 take_status,
	input logic [srrb_pkg::CNT_W-1:0] level
);

	// a waiting result beat stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	// one item at a time: no accept on the cycle after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted during execution");

	// xoff beat carries the xoff code, otherwise zero
	a_xoff_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (send_valid ? send_byte == srrb_pkg::CODE_XOFF : send_byte == 8'd0))
		else $error("bad send byte");

	// no take data without a taken entry
	a_take_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !take_valid |-> take_data == 8'd0 && take_status == 8'd0)
		else $error("take data without entry");

	// level never above ring depth
	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> level <= srrb_pkg::CNT_W'(srrb_pkg::RING_DEPTH))
		else $error("level above depth");

endmodule

bind serial_rx_ring_buffer_xoff srrb_chk u_srrb_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (item.valid),
	.in_ready    (item.ready),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.send_valid  (result.send_valid),
	.send_byte   (result.send_byte),
	.take_valid  (result.take_valid),
	.take_data   (result.take_data),
	.take_status (result.take_status),
	.level       (result.level)
);

/* sim/tb_serial_rx_ring_buffer_xoff.sv */
// testbench for serial_rx_ring_buffer_xoff: random and directed beats checked
// against a cycle-free predictor of the ring, shift translation and xoff logic
// depends on srrb_pkg and the srrb_item_if / srrb_result_if interfaces
`timescale 1ns / 100ps

module tb_serial_rx_ring_buffer_xoff;

	localparam logic [1:0]                     KIND_NONE      = 2'd3;
	localparam logic [srrb_pkg::CFG_IDX_W-1:0] CFG_UNUSED     = 3'd7;
	localparam int                             WATCHDOG_LIMIT = 1000;
	localparam int                             PHASES         = 8;
	localparam int                             PHASE_BEATS    = 175;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] rx_byte;
		logic [7:0] line_status;
		logic [7:0] modem_bits;
	} rx_beat_t;

	typedef struct packed {
		logic                       stored;
		logic                       send_valid;
		logic [7:0]                 send_byte;
		logic                       take_valid;
		logic [7:0]                 take_data;
		logic [7:0]                 take_status;
		logic                       overflow;
		logic [srrb_pkg::CNT_W-1:0] level;
	} ring_result_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_we;
	logic [srrb_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [srrb_pkg::CFG_DATA_W-1:0] cfg_data;

	srrb_item_if   item_ch ();
	srrb_result_if res_ch ();

	serial_rx_ring_buffer_xoff dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item_ch),
		.result    (res_ch)
	);

	always #1 clk = ~clk;

	// predicted ring contents and flags
	logic [srrb_pkg::ENTRY_W-1:0] ring_copy [srrb_pkg::RING_DEPTH];
	logic [srrb_pkg::IDX_W-1:0]   wr_ptr;
	logic [srrb_pkg::IDX_W-1:0]   rd_ptr;
	int unsigned                  fill_count;
	bit                           ring_full;
	bit                           xoff_out;
	bit                           ovf_flag;
	bit                           shift_out;

	// predicted register settings
	bit                           si_so_on;
	bit                           del_on;
	bit                           del_null;
	bit                           flow_on;
	logic [srrb_pkg::THR_W-1:0]   thr;

	rx_beat_t     beats_to_send [$];
	ring_result_t awaited_results [$];
	int unsigned  mismatches;
	int unsigned  quiet_cycles;
	int unsigned  tx_gap_left;
	int unsigned  rx_stall_left;
	bit           tx_idle_on;
	bit           rx_stall_on;

	// one beat through the ring, updating the predicted state
	function automatic ring_result_t ring_predict(input rx_beat_t b);
		ring_result_t r;
		logic [7:0]   ch;
		logic [7:0]   st;
		bit           swallow;
		r = '0;
		ch = b.rx_byte;
		st = (b.line_status & srrb_pkg::MASK_LSR) | (b.modem_bits & ~srrb_pkg::MASK_LSR);
		swallow = 1'b0;
		case (b.kind)
		srrb_pkg::KIND_RX: begin
			if (ring_full) begin
				ovf_flag = 1'b1;
			end else begin
				// shift translation: so/si swallowed, printable bytes get bit 7 from the shift state
				if (si_so_on) begin
					if (ch >= srrb_pkg::CODE_SPACE) begin
						ch = shift_out ? (ch | srrb_pkg::MASK_BIT7) : (ch & srrb_pkg::MASK_LOW7);
					end else if (ch == srrb_pkg::CODE_SO) begin
						shift_out = 1'b1;
						swallow = 1'b1;
					end else if (ch == srrb_pkg::CODE_SI) begin
						shift_out = 1'b0;
						swallow = 1'b1;
					end
				end
				if (!swallow) begin
					if (del_on && del_null && ch[6:0] == srrb_pkg::CODE_DEL7)
						ch = '0;
					ring_copy[wr_ptr] = {ch, st};
					wr_ptr = (wr_ptr == srrb_pkg::IDX_W'(srrb_pkg::RING_DEPTH - 1)) ? '0 :
						wr_ptr + 1'b1;
					fill_count++;
					r.stored = 1'b1;
					if (wr_ptr == rd_ptr)
						ring_full = 1'b1;
					if (flow_on && !xoff_out && fill_count >= thr) begin
						r.send_valid = 1'b1;
						r.send_byte = srrb_pkg::CODE_XOFF;
						xoff_out = 1'b1;
					end
				end
			end
		end
		srrb_pkg::KIND_TAKE: begin
			if (fill_count > 0) begin
				r.take_valid = 1'b1;
				{r.take_data, r.take_status} = ring_copy[rd_ptr];
				rd_ptr = (rd_ptr == srrb_pkg::IDX_W'(srrb_pkg::RING_DEPTH - 1)) ? '0 :
					rd_ptr + 1'b1;
				fill_count--;
				ring_full = 1'b0;
			end
		end
		srrb_pkg::KIND_RELEASE: begin
			xoff_out = 1'b0;
			ovf_flag = 1'b0;
		end
		default: begin
		end
		endcase
		r.overflow = ovf_flag;
		r.level = srrb_pkg::CNT_W'(fill_count);
		return r;
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int unsigned idle_len(input bit on);
		int unsigned roll;
		if (!on)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic rx_beat_t mk_beat(input logic [1:0] kind, input logic [7:0] ch,
		input logic [7:0] ls, input logic [7:0] mb);
		return {kind, ch, ls, mb};
	endfunction

	// random beat; filling bursts are mostly received bytes, draining mostly takes
	function automatic rx_beat_t random_beat(input bit filling);
		rx_beat_t    b;
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (filling)
			b.kind = (roll < 88) ? srrb_pkg::KIND_RX : (roll < 96) ? srrb_pkg::KIND_TAKE :
				(roll < 99) ? srrb_pkg::KIND_RELEASE : KIND_NONE;
		else
			b.kind = (roll < 30) ? srrb_pkg::KIND_RX : (roll < 94) ? srrb_pkg::KIND_TAKE :
				(roll < 98) ? srrb_pkg::KIND_RELEASE : KIND_NONE;
		roll = $urandom_range(0, 99);
		if (roll < 8)
			b.rx_byte = srrb_pkg::CODE_SO;
		else if (roll < 16)
			b.rx_byte = srrb_pkg::CODE_SI;
		else if (roll < 22)
			b.rx_byte = {1'($urandom_range(0, 1)), srrb_pkg::CODE_DEL7};
		else
			b.rx_byte = 8'($urandom_range(0, 255));
		b.line_status = 8'($urandom_range(0, 255));
		b.modem_bits = 8'($urandom_range(0, 255));
		return b;
	endfunction

	task automatic write_reg(input logic [srrb_pkg::CFG_IDX_W-1:0] idx,
		input logic [srrb_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
		srrb_pkg::CFG_SI_SO:     si_so_on = val[0];
		srrb_pkg::CFG_DEL_EN:    del_on = val[0];
		srrb_pkg::CFG_DEL_NULL:  del_null = val[0];
		srrb_pkg::CFG_FLOW_EN:   flow_on = val[0];
		srrb_pkg::CFG_THRESHOLD: thr = val;
		default: begin
		end
		endcase
	endtask

	// single-bit registers get random upper data bits
	task automatic write_flags(input bit si_so, input bit del, input bit dnull, input bit flow,
		input logic [srrb_pkg::THR_W-1:0] threshold);
		write_reg(srrb_pkg::CFG_SI_SO, {6'($urandom), si_so});
		write_reg(srrb_pkg::CFG_DEL_EN, {6'($urandom), del});
		write_reg(srrb_pkg::CFG_DEL_NULL, {6'($urandom), dnull});
		write_reg(srrb_pkg::CFG_FLOW_EN, {6'($urandom), flow});
		write_reg(srrb_pkg::CFG_THRESHOLD, threshold);
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (beats_to_send.size() != 0 || item_ch.valid || awaited_results.size() != 0);
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s mismatch, expected %02h, got %02h", $realtime, name, want, got);
		end
	endtask

	// driver: predicts each accepted beat, then offers the next one after its gap
	always @(posedge clk) begin
		rx_beat_t b;
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			tx_gap_left = 0;
		end else begin
			if (item_ch.valid && item_ch.ready)
				awaited_results.push_back(ring_predict({item_ch.kind, item_ch.rx_byte,
					item_ch.line_status, item_ch.modem_bits}));
			if (!item_ch.valid || item_ch.ready) begin
				if (tx_gap_left > 0) begin
					tx_gap_left--;
					item_ch.valid <= 1'b0;
				end else if (beats_to_send.size() != 0) begin
					b = beats_to_send.pop_front();
					{item_ch.kind, item_ch.rx_byte, item_ch.line_status, item_ch.modem_bits} <= b;
					item_ch.valid <= 1'b1;
					tx_gap_left = idle_len(tx_idle_on);
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: each result beat against the oldest prediction
	always @(posedge clk) begin
		ring_result_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			rx_stall_left = 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (awaited_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result beat with nothing predicted", $realtime);
				end else begin
					want = awaited_results.pop_front();
					check_field("stored", 8'(want.stored), 8'(res_ch.stored));
					check_field("send_valid", 8'(want.send_valid), 8'(res_ch.send_valid));
					check_field("send_byte", want.send_byte, res_ch.send_byte);
					check_field("take_valid", 8'(want.take_valid), 8'(res_ch.take_valid));
					check_field("take_data", want.take_data, res_ch.take_data);
					check_field("take_status", want.take_status, res_ch.take_status);
					check_field("overflow", 8'(want.overflow), 8'(res_ch.overflow));
					check_field("level", 8'(want.level), 8'(res_ch.level));
				end
				rx_stall_left = idle_len(rx_stall_on);
			end else if (rx_stall_left == 0 && rx_stall_on && $urandom_range(0, 19) == 0) begin
				rx_stall_left = idle_len(rx_stall_on);
			end
			if (rx_stall_left > 0) begin
				rx_stall_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if (!arst_n || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// stimulus
	initial begin
		int          n;
		int          burst;
		bit          filling;
		// every input known from the start
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item_ch.valid = 1'b0;
		item_ch.kind = srrb_pkg::KIND_RX;
		item_ch.rx_byte = '0;
		item_ch.line_status = '0;
		item_ch.modem_bits = '0;
		res_ch.ready = 1'b0;
		mismatches = 0;
		quiet_cycles = 0;
		tx_gap_left = 0;
		rx_stall_left = 0;
		tx_idle_on = 1'b1;
		rx_stall_on = 1'b1;
		wr_ptr = '0;
		rd_ptr = '0;
		fill_count = 0;
		ring_full = 1'b0;
		xoff_out = 1'b0;
		ovf_flag = 1'b0;
		shift_out = 1'b0;
		si_so_on = 1'b0;
		del_on = 1'b0;
		del_null = 1'b0;
		flow_on = 1'b0;
		thr = srrb_pkg::THRESHOLD_RST;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: everything on, low threshold
		write_flags(1'b1, 1'b1, 1'b1, 1'b1, srrb_pkg::THR_W'(3));
		// take from empty, then unknown kind
		beats_to_send.push_back(mk_beat(srrb_pkg::KIND_TAKE, 8'h00, 8'h00, 8'h00));
		beats_to_send.push_back(mk_beat(KIND_NONE, 8'hff, 8'hff, 8'hff));
		// shift out swallowed, letter gets bit 7, shifted del to zero
		beats_to_send.push_back(mk_beat(srrb_pkg::KIND_RX, srrb_pkg::CODE_SO, 8'h55, 8'haa));
		beats_to_send.push_back(mk_beat(srrb_pkg::KIND_RX, 8'h41, 8'hff, 8'h00));
		beats_to_send.push_back(mk_beat(srrb_pkg::KIND_RX, 8'h7f, 8'h00, 8'hff));
		// shift in swallowed, del with xoff on level 3
		beats_to_send.push_back(mk_beat(srrb_pkg::KIND_RX, srrb_pkg::CODE_SI, 8'h12, 8'h34));
		beats_to_send.push_back(mk_beat(srrb_pkg::KIND_RX, 8'hff, 8'hab, 8'hcd));
		// control byte kept, no second xoff
		beats_to_send.push_back(mk_beat(srrb_pkg::KIND_RX, 8'h1f, 8'hfc, 8'h03));
		beats_to_send.push_back(mk_beat(srrb_pkg::KIND_RX, 8'h00, 8'h00, 8'hff));
		beats_to_send.push_back(mk_beat(srrb_pkg::KIND_RELEASE, 8'h00, 8'h00, 8'h00));
		// xoff again after release
		beats_to_send.push_back(mk_beat(srrb_pkg::KIND_RX, srrb_pkg::CODE_SPACE, 8'h80, 8'h01));
		beats_to_send.push_back(mk_beat(srrb_pkg::KIND_RX, 8'hfe, 8'hff, 8'hff));
		// drain to empty, then release
		repeat (7)
			beats_to_send.push_back(mk_beat(srrb_pkg::KIND_TAKE, 8'hff, 8'hff, 8'hff));
		beats_to_send.push_back(mk_beat(srrb_pkg::KIND_RELEASE, 8'hff, 8'hff, 8'hff));
		wait_idle();

		// random phases, each started from an idle block with fresh settings
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
			0: write_flags(1'b0, 1'b0, 1'b0, 1'b0, '0);
			1: write_flags(1'b1, 1'b1, 1'b1, 1'b1, srrb_pkg::THR_W'(srrb_pkg::RING_DEPTH));
			2: write_flags(1'($urandom), 1'($urandom), 1'($urandom), 1'b1, '1);
			3: begin
				write_flags(1'($urandom), 1'b1, 1'($urandom), 1'b1, '0);
				write_reg(CFG_UNUSED, srrb_pkg::CFG_DATA_W'($urandom));
			end
			default: write_flags(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
				srrb_pkg::THR_W'($urandom_range(0, srrb_pkg::RING_DEPTH + 6)));
			endcase
			tx_idle_on = (ph % 4 != 1);
			rx_stall_on = (ph % 3 != 2);
			n = 0;
			while (n < PHASE_BEATS) begin
				burst = $urandom_range(16, 100);
				filling = 1'($urandom_range(0, 1));
				for (int j = 0; j < burst; j++)
					beats_to_send.push_back(random_beat(filling));
				n += burst;
			end
			// sender holds off until every result of the phase is back
			wait_idle();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0 && awaited_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

/* files.f */
hdl/srrb_pkg.sv
hdl/srrb_if.sv
hdl/srrb_ctrl.sv
hdl/srrb_dpath.sv
hdl/serial_rx_ring_buffer_xoff.sv
hdl/srrb_chk.sv
sim/tb_serial_rx_ring_buffer_xoff.sv
